FILE: sv/typed_operand_stack_top_defines.svh
// Assertion macros for the typed operand stack.
// Used by typed_operand_stack_top; depends on clk_i and rst_ni in the including scope.
`ifndef TYPED_OPERAND_STACK_TOP_DEFINES_SVH
`define TYPED_OPERAND_STACK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TOS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TOS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tos_pkg.sv
// Shared types and constants of the typed operand stack.
// No dependencies; imported by tos_stack and typed_operand_stack_top.
`timescale 1ns / 1ps

package tos_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned RTYPE_W     = 16;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INT  = 2'd1,
    KIND_LONG = 2'd2,
    KIND_REF  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FN_PUSH_INT  = 3'd0,
    FN_PUSH_LONG = 3'd1,
    FN_PUSH_REF  = 3'd2,
    FN_POP       = 3'd3,
    FN_POP2      = 3'd4,
    FN_DUP       = 3'd5,
    FN_DUP2      = 3'd6,
    FN_SWAP      = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_KIND     = 3'd2,
    ST_FEW      = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [RTYPE_W-1:0]   ref_type;
    logic [VALUE_W-1:0]   value;
  } entry_t;

  // Request from the sequencer to the stack datapath.
  typedef struct packed {
    logic                 start;
    logic                 exec;
    func_e                func;
    logic [VALUE_W-1:0]   value;
    logic [RTYPE_W-1:0]   ref_type;
  } stk_req_t;

  // Outcome of the request being executed.
  typedef struct packed {
    status_e              status;
    logic [CNT_W-1:0]     cur_count;
    logic [CNT_W-1:0]     count;
    entry_t               top;
  } stk_rsp_t;

  function automatic logic is_single(kind_e k);
    return (k == KIND_INT) || (k == KIND_REF);
  endfunction

endpackage

FILE: sv/tos_stack.sv
// Stack datapath: top entry in a register, lower entries in a synchronous memory.
// Depends on tos_pkg.
`timescale 1ns / 1ps

module tos_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tos_pkg::stk_req_t req_i,
  output tos_pkg::stk_rsp_t rsp_o
);
  import tos_pkg::*;

  entry_t             mem [STACK_DEPTH];
  entry_t             rd_q;
  entry_t             top_q, top_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_en;
  logic               full, empty;
  status_e            status;
  entry_t             push_e;

  assign full   = (cnt_q == CNT_W'(STACK_DEPTH));
  assign empty  = (cnt_q == '0);
  // The entry just below the top lives at count minus two.
  assign rd_idx = IDX_W'(cnt_q - CNT_W'(2));

  always_comb begin
    push_e = '0;
    unique case (req_i.func)
      FN_PUSH_INT: begin
        push_e.kind  = KIND_INT;
        push_e.value = {{32{req_i.value[31]}}, req_i.value[31:0]};
      end
      FN_PUSH_LONG: begin
        push_e.kind  = KIND_LONG;
        push_e.value = req_i.value;
      end
      default: begin
        push_e.kind     = KIND_REF;
        push_e.value    = req_i.value;
        push_e.ref_type = req_i.ref_type;
      end
    endcase
  end

  always_comb begin
    status = ST_OK;
    cnt_d  = cnt_q;
    top_d  = top_q;
    wr_en  = 1'b0;
    wr_idx = IDX_W'(cnt_q - CNT_W'(1));
    unique case (req_i.func)
      FN_PUSH_INT, FN_PUSH_LONG, FN_PUSH_REF: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          wr_en = !empty;
          top_d = push_e;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      FN_POP, FN_POP2: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if ((req_i.func == FN_POP) ? is_single(top_q.kind)
                                            : (top_q.kind == KIND_LONG)) begin
          top_d = rd_q;
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          status = ST_KIND;
        end
      end
      FN_DUP, FN_DUP2: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (!((req_i.func == FN_DUP) ? is_single(top_q.kind)
                                              : (top_q.kind == KIND_LONG))) begin
          status = ST_KIND;
        end else if (full) begin
          status = ST_OVERFLOW;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        if (cnt_q < CNT_W'(2)) begin
          status = ST_FEW;
        end else if (!is_single(top_q.kind) || !is_single(rd_q.kind)) begin
          status = ST_KIND;
        end else begin
          wr_en  = 1'b1;
          wr_idx = rd_idx;
          top_d  = rd_q;
        end
      end
    endcase
  end

  // Reads happen only in the accept cycle and writes only in the execute cycle,
  // so the two never touch the memory in the same cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.exec && wr_en) begin
      mem[wr_idx] <= top_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.exec) begin
      top_q <= top_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  assign rsp_o.status    = status;
  assign rsp_o.cur_count = cnt_q;
  assign rsp_o.count     = cnt_d;
  assign rsp_o.top       = top_d;

endmodule

FILE: sv/typed_operand_stack_top.sv
// Typed operand stack: one operation per request and one result per request.
// Depends on tos_pkg, tos_stack and typed_operand_stack_top_defines.svh.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation code,
//   tdata the value to push and the reference type id. Each request yields
//   exactly one result on the m_axis channel with the status, the new depth
//   and the new top entry (kind in tuser, the rest in tdata).
//   Each request has an accept cycle and an execute step: the accept cycle reads the
//   entry below the top from the stack memory into a register, and the execute step
//   then updates the top register, the count and the memory. No new request is
//   accepted until the one in progress has executed; the result is written into
//   the output register at the execute edge.
//   A new request is accepted while an earlier result still waits in the
//   output register; if the receiver stalls, the request in progress holds in
//   its execute step until the output register frees up.
//   Reset clears the entry count and all handshake state; the stack memory
//   needs no clearing since entries at or above the count never reach a result.
`timescale 1ns / 1ps

`include "typed_operand_stack_top_defines.svh"

module typed_operand_stack_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [63:0] value, [79:64] ref_type
  input  logic [79:0] s_axis_tdata,
  // [2:0] func
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [3] is_empty, [10:4] depth, [74:11] top_value,
  // [90:75] top_ref_type, [95:91] zero
  output logic [95:0] m_axis_tdata,
  // [1:0] top_kind
  output logic [1:0]  m_axis_tuser
);
  import tos_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EX   = 1'b1;

  logic               state_q, state_d;
  logic               start, exec;
  func_e              func_q;
  logic [VALUE_W-1:0] value_q;
  logic [RTYPE_W-1:0] rtype_q;
  stk_req_t           req;
  stk_rsp_t           rsp;
  logic               out_valid_q;
  logic [95:0]        out_data_q, out_data_d;
  logic [1:0]         out_kind_q, out_kind_d;
  logic               res_empty;

  assign s_axis_tready = (state_q == S_IDLE);
  assign start         = s_axis_tvalid && s_axis_tready;
  assign exec          = (state_q == S_EX) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    if (start) begin
      state_d = S_EX;
    end else if (exec) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      func_q  <= func_e'(s_axis_tuser);
      value_q <= s_axis_tdata[63:0];
      rtype_q <= s_axis_tdata[79:64];
    end
  end

  assign req.start    = start;
  assign req.exec     = exec;
  assign req.func     = func_q;
  assign req.value    = value_q;
  assign req.ref_type = rtype_q;

  tos_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign res_empty = (rsp.count == '0);

  always_comb begin
    out_data_d        = '0;
    out_kind_d        = KIND_NONE;
    out_data_d[2:0]   = rsp.status;
    out_data_d[3]     = res_empty;
    out_data_d[10:4]  = DEPTH_W'(rsp.count);
    if (!res_empty) begin
      out_kind_d        = rsp.top.kind;
      out_data_d[74:11] = rsp.top.value;
      if (rsp.top.kind == KIND_REF) begin
        out_data_d[90:75] = rsp.top.ref_type;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  `TOS_ASSERT_NXT(a_accept_to_exec, start, state_q == S_EX, "accepted request did not execute")
  `TOS_ASSERT_IMP(a_count_bound, 1'b1, rsp.cur_count <= CNT_W'(STACK_DEPTH), "count beyond depth")
  `TOS_ASSERT_NXT(a_error_keeps_count, exec && (rsp.status != ST_OK),
                  rsp.cur_count == $past(rsp.cur_count), "failed request changed the count")

endmodule

FILE: tb/tb_typed_operand_stack_top.sv
// Self-checking testbench for typed_operand_stack_top: directed and random stack operations.
// Depends on tos_pkg and the RTL of typed_operand_stack_top; results are checked in order
// against a behavioral stack kept by a small scoreboard class.
`timescale 1ns / 1ps

module tb_typed_operand_stack_top;
  import tos_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX = 10;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } gen_mode_e;

  // What one result of the block shows about the stack after a request.
  typedef struct {
    status_e            status;
    logic               is_empty;
    logic [DEPTH_W-1:0] depth;
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [RTYPE_W-1:0] ref_type;
  } stack_view_t;

  class stack_scoreboard;
    entry_t      entries[STACK_DEPTH];
    int unsigned depth;
    stack_view_t expected_views[$];
    int unsigned mismatches;

    function new();
      depth = 0;
      mismatches = 0;
    endfunction

    function bit one_slot(kind_e k);
      return (k == KIND_INT) || (k == KIND_REF);
    endfunction

    function status_e push_entry(kind_e k, logic [VALUE_W-1:0] v, logic [RTYPE_W-1:0] rt);
      if (depth >= STACK_DEPTH) return ST_OVERFLOW;
      entries[depth].kind = k;
      entries[depth].value = v;
      entries[depth].ref_type = (k == KIND_REF) ? rt : '0;
      depth++;
      return ST_OK;
    endfunction

    // Applies one accepted request to the stack and queues the view it must produce.
    function void note_request(func_e f, logic [VALUE_W-1:0] v, logic [RTYPE_W-1:0] rt);
      status_e     st;
      entry_t      top;
      entry_t      tmp;
      bit          legal;
      stack_view_t view;
      st = ST_OK;
      if (depth != 0) top = entries[depth-1];
      case (f)
        FN_PUSH_INT:  st = push_entry(KIND_INT, {{32{v[31]}}, v[31:0]}, '0);
        FN_PUSH_LONG: st = push_entry(KIND_LONG, v, '0);
        FN_PUSH_REF:  st = push_entry(KIND_REF, v, rt);
        FN_POP, FN_POP2, FN_DUP, FN_DUP2: begin
          if (depth == 0) begin
            st = ST_EMPTY;
          end else begin
            legal = (f == FN_POP || f == FN_DUP) ? one_slot(top.kind) : (top.kind == KIND_LONG);
            if (!legal) begin
              st = ST_KIND;
            end else if (f == FN_POP || f == FN_POP2) begin
              depth--;
            end else begin
              st = push_entry(top.kind, top.value, top.ref_type);
            end
          end
        end
        default: begin
          if (depth < 2) begin
            st = ST_FEW;
          end else if (!one_slot(entries[depth-1].kind) || !one_slot(entries[depth-2].kind)) begin
            st = ST_KIND;
          end else begin
            tmp = entries[depth-1];
            entries[depth-1] = entries[depth-2];
            entries[depth-2] = tmp;
          end
        end
      endcase
      view.status = st;
      view.is_empty = (depth == 0);
      view.depth = depth[DEPTH_W-1:0];
      if (depth == 0) begin
        view.kind = KIND_NONE;
        view.value = '0;
        view.ref_type = '0;
      end else begin
        view.kind = entries[depth-1].kind;
        view.value = entries[depth-1].value;
        view.ref_type = (view.kind == KIND_REF) ? entries[depth-1].ref_type : '0;
      end
      expected_views.push_back(view);
    endfunction

    function void check_result(logic [95:0] data, logic [1:0] kind);
      stack_view_t exp_v;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result with no request pending: data=%h kind=%0d", $realtime, data,
                   kind);
        return;
      end
      exp_v = expected_views.pop_front();
      if (data[2:0] !== exp_v.status || data[3] !== exp_v.is_empty ||
          data[10:4] !== exp_v.depth || kind !== exp_v.kind ||
          data[74:11] !== exp_v.value || data[90:75] !== exp_v.ref_type) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("[%0t] result mismatch: expected st=%0d empty=%0b depth=%0d kind=%0d",
                   $realtime, exp_v.status, exp_v.is_empty, exp_v.depth, exp_v.kind);
          $display("  expected value=%h rtype=%h", exp_v.value, exp_v.ref_type);
          $display("  got st=%0d empty=%0b depth=%0d kind=%0d value=%h rtype=%h",
                   data[2:0], data[3], data[10:4], kind, data[74:11], data[90:75]);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [63:0] value, [79:64] ref_type
  logic [79:0] s_axis_tdata = '0;
  // [2:0] func
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [2:0] status, [3] is_empty, [10:4] depth, [74:11] top_value, [90:75] top_ref_type
  logic [95:0] m_axis_tdata;
  // [1:0] top_kind
  logic [1:0]  m_axis_tuser;

  stack_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     quiet_cycles = 0;
  gen_mode_e       gen_mode = MODE_MIXED;
  int              mode_left = 0;

  typed_operand_stack_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Holds the request until it is taken; idle cycles go in front of it.
  task automatic send_request(input func_e f, input logic [VALUE_W-1:0] v,
                              input logic [RTYPE_W-1:0] rt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rt, v};
    s_axis_tuser <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(f, v, rt);
  endtask

  task automatic take_results();
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '1;
      3: return '0;
      4: return {$urandom, 1'b1, 31'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [RTYPE_W-1:0] rand_ref_type();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly operations that are legal for the current top; a tenth are arbitrary.
  function automatic func_e pick_func();
    int unsigned roll;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned dup_pct;
    func_e       any_push;
    bit          top_long;
    roll = $urandom_range(99);
    any_push = func_e'(int'(FN_PUSH_INT) + $urandom_range(2));
    if ($urandom_range(9) == 0) return func_e'($urandom_range(7));
    if (sb.depth == 0) return any_push;
    top_long = (sb.entries[sb.depth-1].kind == KIND_LONG);
    case (gen_mode)
      MODE_FILL:  begin push_pct = 80; pop_pct = 6;  dup_pct = 8;  end
      MODE_DRAIN: begin push_pct = 20; pop_pct = 60; dup_pct = 8;  end
      default:    begin push_pct = 40; pop_pct = 35; dup_pct = 12; end
    endcase
    if (roll < push_pct) return any_push;
    if (roll < push_pct + pop_pct) return top_long ? FN_POP2 : FN_POP;
    if (roll < push_pct + pop_pct + dup_pct) return top_long ? FN_DUP2 : FN_DUP;
    if (sb.depth >= 2 && sb.one_slot(sb.entries[sb.depth-1].kind) &&
        sb.one_slot(sb.entries[sb.depth-2].kind))
      return FN_SWAP;
    return any_push;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned send_pct,
                           input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) begin
      if (mode_left <= 0) begin
        gen_mode = gen_mode_e'($urandom_range(2));
        mode_left = $urandom_range(100, 20);
      end
      mode_left--;
      send_request(pick_func(), rand_value(), rand_ref_type());
    end
  endtask

  initial begin
    fork
      take_results();
    join_none
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Error paths on an empty stack and with a single entry, then each kind rule.
    send_request(FN_POP, '0, '0);
    send_request(FN_POP2, '0, '0);
    send_request(FN_DUP, '0, '0);
    send_request(FN_DUP2, '0, '0);
    send_request(FN_SWAP, '0, '0);
    send_request(FN_PUSH_INT, 64'h1234_5678_8000_0000, '1);
    send_request(FN_SWAP, '0, '0);
    send_request(FN_PUSH_INT, 64'hFFFF_FFFF_7FFF_FFFF, '1);
    send_request(FN_SWAP, '0, '0);
    send_request(FN_PUSH_REF, '1, '1);
    send_request(FN_DUP, '0, '0);
    send_request(FN_POP2, '0, '0);
    send_request(FN_DUP2, '0, '0);
    send_request(FN_SWAP, '0, '0);
    send_request(FN_POP, '0, '0);
    send_request(FN_PUSH_LONG, 64'h8000_0000_0000_0000, 16'hABCD);
    send_request(FN_POP, '0, '0);
    send_request(FN_DUP, '0, '0);
    send_request(FN_SWAP, '0, '0);
    send_request(FN_DUP2, '0, '0);
    send_request(FN_POP2, '0, '0);
    send_request(FN_PUSH_REF, '0, '0);
    send_request(FN_SWAP, '0, '0);
    send_request(FN_PUSH_LONG, 64'h7FFF_FFFF_FFFF_FFFF, '1);
    send_request(FN_POP2, '0, '0);

    run_phase(100, 0, 0);
    run_phase(100, 81, 0);
    run_phase(100, 0, 81);
    run_phase(100, 15, 15);
    run_phase(100, 0, 0);
    run_phase(100, 81, 0);
    run_phase(100, 0, 81);
    run_phase(100, 15, 15);
    s_axis_tvalid <= 1'b0;

    while (sb.expected_views.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
